@@ rtl/mhd_pkg.sv @@
// Package for the message header deframer.
// Holds the result kinds, action codes, dispatch lookup and the result record type.
// No dependencies.
package mhd_pkg;

	localparam int HDR_LEN = 16;
	localparam logic [15:0] MAX_BODY = 16'd16384;
	localparam int TABLE_LEN = 28;
	localparam int TDATA_W = 144;
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_BODY     = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_TOO_BIG  = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		ACT_NOOP         = 5'd0,
		ACT_EVENT        = 5'd1,
		ACT_READ         = 5'd2,
		ACT_READ_SYNC    = 5'd3,
		ACT_EXCEPTION    = 5'd4,
		ACT_CLEAR        = 5'd5,
		ACT_READ_NOTIFY  = 5'd6,
		ACT_CLAIM        = 5'd7,
		ACT_WRITE_NOTIFY = 5'd8,
		ACT_ACCESS       = 5'd9,
		ACT_ECHO         = 5'd10,
		ACT_DISCONNECT   = 5'd11,
		ACT_BAD          = 5'd12,
		ACT_SEARCH       = 5'd13,
		ACT_BEACON       = 5'd14,
		ACT_NOT_HERE     = 5'd15,
		ACT_REPEATER_ACK = 5'd16
	} act_t;

	typedef struct packed {
		kind_t       kind;
		logic        last;
		logic [7:0]  body_byte;
		act_t        action;
		logic [15:0] command;
		logic [15:0] body_size;
		logic [15:0] data_type;
		logic [15:0] element_count;
		logic [31:0] channel_word;
		logic [31:0] available_word;
	} res_t;

	function automatic act_t lookup_action(input logic [15:0] cmd, input logic dgram);
		act_t act;
		act = ACT_BAD;
		if (cmd < 16'(TABLE_LEN)) begin
			if (dgram) begin
				case (cmd[4:0])
					5'd0:    act = ACT_NOOP;
					5'd6:    act = ACT_SEARCH;
					5'd13:   act = ACT_BEACON;
					5'd14:   act = ACT_NOT_HERE;
					5'd17:   act = ACT_REPEATER_ACK;
					default: act = ACT_BAD;
				endcase
			end else begin
				case (cmd[4:0])
					5'd0:    act = ACT_NOOP;
					5'd1:    act = ACT_EVENT;
					5'd3:    act = ACT_READ;
					5'd10:   act = ACT_READ_SYNC;
					5'd11:   act = ACT_EXCEPTION;
					5'd12:   act = ACT_CLEAR;
					5'd15:   act = ACT_READ_NOTIFY;
					5'd18:   act = ACT_CLAIM;
					5'd19:   act = ACT_WRITE_NOTIFY;
					5'd22:   act = ACT_ACCESS;
					5'd23:   act = ACT_ECHO;
					5'd26:   act = ACT_DISCONNECT;
					5'd27:   act = ACT_DISCONNECT;
					default: act = ACT_BAD;
				endcase
			end
		end
		return act;
	endfunction

endpackage

@@ rtl/mhd_core.sv @@
// Deframing core: header store, byte counters, discard flag and table select register.
// Turns one registered byte into up to two result records combinationally.
// Depends on mhd_pkg.
module mhd_core import mhd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       adv,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	output logic [1:0] res_cnt,
	output res_t       res0,
	output res_t       res1
);

	logic        dgram_q;
	logic [4:0]  hdr_cnt_q;
	logic [7:0]  hdr_q [HDR_LEN];
	logic [15:0] body_cnt_q;
	logic        discard_q;

	logic [7:0]  hdr_nxt [HDR_LEN];
	logic [4:0]  hdr_cnt_d;
	logic [15:0] body_cnt_d;
	logic        discard_d;
	logic        hdr_wr;
	logic [4:0]  hdr_cnt_inc;
	logic [16:0] body_cnt_inc;
	res_t        base;

	assign hdr_wr = !discard_q && (hdr_cnt_q < 5'(HDR_LEN));
	assign hdr_cnt_inc = hdr_cnt_q + 5'd1;
	assign body_cnt_inc = {1'b0, body_cnt_q} + 17'd1;

	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_nxt[i] = hdr_q[i];
		end
		if (hdr_wr) begin
			hdr_nxt[hdr_cnt_q[3:0]] = in_byte;
		end
	end

	always_comb begin
		base.kind           = KIND_BODY;
		base.last           = 1'b0;
		base.body_byte      = 8'd0;
		base.action         = ACT_NOOP;
		base.command        = {hdr_nxt[0], hdr_nxt[1]};
		base.body_size      = {hdr_nxt[2], hdr_nxt[3]};
		base.data_type      = {hdr_nxt[4], hdr_nxt[5]};
		base.element_count  = {hdr_nxt[6], hdr_nxt[7]};
		base.channel_word   = {hdr_nxt[8], hdr_nxt[9], hdr_nxt[10], hdr_nxt[11]};
		base.available_word = {hdr_nxt[12], hdr_nxt[13], hdr_nxt[14], hdr_nxt[15]};
	end

	always_comb begin
		res_cnt    = 2'd0;
		res0       = base;
		res1       = base;
		hdr_cnt_d  = hdr_cnt_q;
		body_cnt_d = body_cnt_q;
		discard_d  = discard_q;
		if (discard_q) begin
			if (in_end) begin
				discard_d = 1'b0;
			end
		end else if (hdr_wr) begin
			hdr_cnt_d = hdr_cnt_inc;
			if (hdr_cnt_inc == 5'(HDR_LEN)) begin
				if (base.body_size > MAX_BODY) begin
					res_cnt    = 2'd1;
					res0.kind  = KIND_TOO_BIG;
					res0.last  = 1'b1;
					hdr_cnt_d  = 5'd0;
					body_cnt_d = 16'd0;
					discard_d  = !in_end;
				end else if (base.body_size == 16'd0) begin
					res_cnt     = 2'd1;
					res0.kind   = KIND_COMPLETE;
					res0.action = lookup_action(base.command, dgram_q);
					res0.last   = 1'b1;
					hdr_cnt_d   = 5'd0;
					body_cnt_d  = 16'd0;
				end
			end
		end else begin
			res_cnt        = 2'd1;
			res0.kind      = KIND_BODY;
			res0.body_byte = in_byte;
			res0.last      = 1'b1;
			body_cnt_d     = body_cnt_inc[15:0];
			if (body_cnt_inc >= {1'b0, base.body_size}) begin
				res_cnt     = 2'd2;
				res0.last   = 1'b0;
				res1.kind   = KIND_COMPLETE;
				res1.action = lookup_action(base.command, dgram_q);
				res1.last   = 1'b1;
				hdr_cnt_d   = 5'd0;
				body_cnt_d  = 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dgram_q    <= 1'b0;
			hdr_cnt_q  <= 5'd0;
			body_cnt_q <= 16'd0;
			discard_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dgram_q <= cfg_wr_data;
			end
			if (adv) begin
				hdr_cnt_q  <= hdr_cnt_d;
				body_cnt_q <= body_cnt_d;
				discard_q  <= discard_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hdr_wr) begin
			hdr_q[hdr_cnt_q[3:0]] <= in_byte;
		end
	end

endmodule

@@ rtl/mhd_res_fifo.sv @@
// Small result queue that takes up to two result records per cycle and gives one.
// Parts the deframing core from the output stream handshake.
// Depends on mhd_pkg.
module mhd_res_fifo import mhd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  res_t       push0,
	input  res_t       push1,
	input  logic       pop,
	output res_t       head,
	output logic       not_empty,
	output logic       room2
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign not_empty = (count_q != '0);
	assign room2 = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign do_pop = pop && not_empty;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_ptr_q + PTR_W'(1)] <= push1;
		end
	end

endmodule

@@ rtl/message_header_deframer_top.sv @@
// Top level of the message header deframer.
// Instantiates the input stage, mhd_core and mhd_res_fifo; depends on mhd_pkg.
//
// Bytes enter one per request on the slave stream, with tlast marking the end of the
// caller's receive block. A request is registered, then processed once the queue has room,
// which writes up to two results into a four-entry queue in front of the master stream.
// One byte can be taken every cycle; the only limit is the queue, which holds the input
// while fewer than two entries are free. The last byte of a body gives two results.
module message_header_deframer_top import mhd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,    // datagram_channel
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // data_byte
	input  logic               s_axis_tlast,   // block_end
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// body_byte, action, command, body_size, data_type, element_count,
	// channel_word, available_word, zero padding
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]         m_axis_tuser,   // kind
	output logic               m_axis_tlast    // last
);

	logic       in_vld_s1;
	logic [7:0] in_byte_s1;
	logic       in_end_s1;
	logic       adv;
	logic [1:0] res_cnt;
	logic [1:0] push_cnt;
	res_t       res0;
	res_t       res1;
	res_t       head;
	logic       not_empty;
	logic       room2;

	assign adv = in_vld_s1 && room2;
	assign s_axis_tready = !in_vld_s1 || adv;
	assign push_cnt = adv ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
			in_end_s1  <= s_axis_tlast;
		end
	end

	mhd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.adv         (adv),
		.in_byte     (in_byte_s1),
		.in_end      (in_end_s1),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	mhd_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.pop       (m_axis_tready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign m_axis_tvalid = not_empty;
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {3'b000, head.available_word, head.channel_word,
		head.element_count, head.data_type, head.body_size, head.command,
		head.action, head.body_byte};

endmodule

@@ rtl/mhd_checker.sv @@
// Port checker for the message header deframer top level, attached by bind.
// Watches the master stream only; depends on mhd_pkg.
module mhd_checker import mhd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]         m_axis_tuser,
	input logic               m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("A stalled result request changed.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == KIND_BODY || m_axis_tuser == KIND_COMPLETE ||
			m_axis_tuser == KIND_TOO_BIG))
		else $error("A result carries an unknown kind.");

	a_body_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_BODY |-> m_axis_tdata[12:8] == ACT_NOOP)
		else $error("A body byte result carries an action.");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_BODY |->
			m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("A completion or error result is not the last of its byte.");

endmodule

bind message_header_deframer_top mhd_checker u_mhd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
